// ===== design/mi_pkg.sv =====
// package for the modular inverse core: widths, sequencer states and unit control types
`timescale 1ns / 1ps

package mi_pkg;

    // default operand width
    localparam int MI_WIDTH = 64;

    // sequencer states
    typedef enum logic [1:0] {
        MI_IDLE,
        MI_CHECK,
        MI_RUN,
        MI_FINISH
    } mi_state_t;

    // control from the sequencer to the divide / multiply-accumulate unit
    typedef struct packed {
        logic start;
    } mi_unit_ctrl_t;

    // status from the unit back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } mi_unit_stat_t;

endpackage

// ===== design/mi_divmac.sv =====
// shared iterative unit: restoring division one quotient bit per cycle, with quotient times coefficient formed on the fly
`timescale 1ns / 1ps

module mi_divmac #(
    parameter int WIDTH = mi_pkg::MI_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mi_pkg::mi_unit_ctrl_t ctrl,
    output mi_pkg::mi_unit_stat_t stat,
    input  logic [WIDTH-1:0]      dividend,
    input  logic [WIDTH-1:0]      divisor,
    input  logic [WIDTH-1:0]      multiplicand,
    output logic [WIDTH-1:0]      remainder,
    output logic [WIDTH-1:0]      product
);
    import mi_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WIDTH - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dvd_reg, dvd_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [WIDTH-1:0] mul_reg, mul_next;
    logic [WIDTH-1:0] acc_reg, acc_next;

    logic [WIDTH:0]   trial;
    logic             q_bit;

    // one restoring step and one horner step of the product, modulo 2^WIDTH
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[WIDTH-1]};
        q_bit     = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        mul_next  = mul_reg;
        acc_next  = acc_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = LAST_BIT;
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            mul_next  = multiplicand;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = q_bit ? WIDTH'(trial - {1'b0, dsr_reg}) : WIDTH'(trial);
            dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
            acc_next = {acc_reg[WIDTH-2:0], 1'b0} + (q_bit ? mul_reg : '0);
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        mul_reg <= mul_next;
        acc_reg <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;
    assign product   = acc_reg;

endmodule

// ===== design/modular_inverse_core.sv =====
// Modular inverse core: value^-1 mod modulus by the extended Euclidean algorithm.
// Input beats arrive on the s_ group: s_tdata holds value (low WIDTH bits) and
// modulus (next WIDTH bits). One result beat leaves on the m_ group: m_tdata holds
// the inverse, m_tuser the no_inverse flag (gcd above one, inverse then 0).
// Each Euclid round runs in the shared divide unit, which produces one quotient
// bit per cycle and accumulates quotient times coefficient alongside. An item
// takes at most about 1.44*WIDTH+2 rounds, far fewer on average.
// s_tready is high only while the core is idle; one item is worked at a time.
// The result sits in an output register; a new item is taken while it waits,
// and a finished item waits in the sequencer until the output register is free,
// so a stalled receiver holds the core back without losing a result.
// Reset (rst_n, asynchronous, active low) drops any item in progress, clears
// m_tvalid and leaves the core ready for a new beat.
`timescale 1ns / 1ps

module modular_inverse_core #(
    parameter int WIDTH = mi_pkg::MI_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // value, modulus
    input  logic [((2*WIDTH+7)/8)*8-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // inverse
    output logic [((WIDTH+7)/8)*8-1:0]          m_tdata,
    // no_inverse
    output logic                                m_tuser
);
    import mi_pkg::*;

    localparam int OUT_W = ((WIDTH+7)/8)*8;

    mi_state_t        state_reg, state_next;
    logic [WIDTH-1:0] mod_reg, mod_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] nr_reg, nr_next;
    logic [WIDTH-1:0] t_reg, t_next;
    logic [WIDTH-1:0] nt_reg, nt_next;
    logic             t_neg_reg, t_neg_next;
    logic             nt_neg_reg, nt_neg_next;
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] inv_reg, inv_next;
    logic             flag_reg, flag_next;

    mi_unit_ctrl_t    unit_ctrl;
    mi_unit_stat_t    unit_stat;
    logic [WIDTH-1:0] unit_rem;
    logic [WIDTH-1:0] unit_prod;

    // shared divide and multiply-accumulate unit
    mi_divmac #(
        .WIDTH(WIDTH)
    ) u_divmac (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (unit_ctrl),
        .stat        (unit_stat),
        .dividend    (r_reg),
        .divisor     (nr_reg),
        .multiplicand(nt_reg),
        .remainder   (unit_rem),
        .product     (unit_prod)
    );

    // sequencer: next state, round updates and result formation
    always_comb
    begin
        state_next      = state_reg;
        mod_next        = mod_reg;
        r_next          = r_reg;
        nr_next         = nr_reg;
        t_next          = t_reg;
        nt_next         = nt_reg;
        t_neg_next      = t_neg_reg;
        nt_neg_next     = nt_neg_reg;
        out_valid_next  = out_valid_reg;
        inv_next        = inv_reg;
        flag_next       = flag_reg;
        unit_ctrl.start = 1'b0;
        s_tready        = (state_reg == MI_IDLE);

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            MI_IDLE:
            begin
                if (s_tvalid)
                begin
                    mod_next    = s_tdata[2*WIDTH-1:WIDTH];
                    r_next      = s_tdata[2*WIDTH-1:WIDTH];
                    nr_next     = s_tdata[WIDTH-1:0];
                    t_next      = '0;
                    nt_next     = WIDTH'(1);
                    t_neg_next  = 1'b1;
                    nt_neg_next = 1'b0;
                    state_next  = MI_CHECK;
                end
            end
            MI_CHECK:
            begin
                if (nr_reg == '0)
                begin
                    state_next = MI_FINISH;
                end
                else
                begin
                    unit_ctrl.start = 1'b1;
                    state_next      = MI_RUN;
                end
            end
            MI_RUN:
            begin
                // apply the quotient to both pairs when the unit finishes
                if (unit_stat.done)
                begin
                    r_next      = nr_reg;
                    nr_next     = unit_rem;
                    t_next      = nt_reg;
                    t_neg_next  = nt_neg_reg;
                    nt_next     = t_reg + unit_prod;
                    nt_neg_next = t_neg_reg;
                    state_next  = MI_CHECK;
                end
            end
            MI_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    if (r_reg > WIDTH'(1))
                    begin
                        inv_next  = '0;
                        flag_next = 1'b1;
                    end
                    else if (t_neg_reg && (t_reg != '0))
                    begin
                        inv_next  = mod_reg - t_reg;
                        flag_next = 1'b0;
                    end
                    else
                    begin
                        inv_next  = t_reg;
                        flag_next = 1'b0;
                    end
                    state_next = MI_IDLE;
                end
            end
            default:
            begin
                state_next = MI_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= MI_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        mod_reg    <= mod_next;
        r_reg      <= r_next;
        nr_reg     <= nr_next;
        t_reg      <= t_next;
        nt_reg     <= nt_next;
        t_neg_reg  <= t_neg_next;
        nt_neg_reg <= nt_neg_next;
        inv_reg    <= inv_next;
        flag_reg   <= flag_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(inv_reg);
    assign m_tuser  = flag_reg;

endmodule
